// File: design/ftmrw_pkg.sv
`timescale 1ns / 1ps

package ftmrw_pkg;

  localparam int unsigned CoordW   = 2;
  localparam int unsigned LinkW    = 36;
  localparam int unsigned LimitW   = 11;
  localparam int unsigned CountW   = 12;
  localparam int unsigned NodeW    = 4;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CoordW-1:0] CoordMax      = 2'd2;
  localparam logic [LinkW-1:0]  LinkOkReset   = {LinkW{1'b1}};
  localparam logic [LimitW-1:0] HopLimitReset = 11'd1000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LINK_OK   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HOP_LIMIT = 1'b1;

  // travel direction; also the bit offset inside a node's link nibble
  typedef enum logic [2:0] {
    DIR_W   = 3'd0,
    DIR_S   = 3'd1,
    DIR_E   = 3'd2,
    DIR_N   = 3'd3,
    DIR_NEW = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    OUT_DELIVERED  = 2'd0,
    OUT_UNROUTABLE = 2'd1,
    OUT_LIVELOCK   = 2'd2
  } outcome_e;

  // decision of the hop unit for the current node
  typedef struct packed {
    logic arrived;  // packet sits on the destination
    logic stuck;    // no turn rule applies and not arrived
    dir_e mv;       // chosen move when neither flag is set
  } hop_res_t;

endpackage

// File: design/ftmrw_hop.sv
`timescale 1ns / 1ps

module ftmrw_hop import ftmrw_pkg::*; (
  input  logic [CoordW-1:0] cur_x_i,
  input  logic [CoordW-1:0] cur_y_i,
  input  logic [CoordW-1:0] dst_x_i,
  input  logic [CoordW-1:0] dst_y_i,
  input  dir_e              heading_i,
  input  logic [3:0]        links_i,
  output hop_res_t          res_o
);

  // one extra bit so that +1 never wraps
  logic [CoordW:0] cx, cy, dx, dy, cx1, cy1, dx1, dy1, cmax;
  logic wok, sok, eok, nok, fromws;
  logic hw, hs, he, hn;
  logic [11:0] rule;

  assign cx   = {1'b0, cur_x_i};
  assign cy   = {1'b0, cur_y_i};
  assign dx   = {1'b0, dst_x_i};
  assign dy   = {1'b0, dst_y_i};
  assign cx1  = cx + 3'd1;
  assign cy1  = cy + 3'd1;
  assign dx1  = dx + 3'd1;
  assign dy1  = dy + 3'd1;
  assign cmax = {1'b0, CoordMax};

  assign wok = links_i[DIR_W[1:0]];
  assign sok = links_i[DIR_S[1:0]];
  assign eok = links_i[DIR_E[1:0]];
  assign nok = links_i[DIR_N[1:0]];

  assign hw = (heading_i == DIR_W);
  assign hs = (heading_i == DIR_S);
  assign he = (heading_i == DIR_E);
  assign hn = (heading_i == DIR_N);
  assign fromws = hw || hs || (heading_i == DIR_NEW);

  // turn rules, highest priority first
  always_comb begin
    rule[0]  = (cx == dx1) && (cy == dy) && wok;
    rule[1]  = (cy == dy1) && (cx == dx) && sok;
    rule[2]  = (cx1 == dx) && (cy == dy) && eok;
    rule[3]  = (cy1 == dy) && (cx == dx) && nok;
    rule[4]  = (cx != '0) && fromws && wok && ((cx >= dx) || ((cy <= dy) && !sok));
    rule[5]  = (cy != '0) && fromws && sok && ((cy >= dy) || ((cx <= dx) && !wok)) &&
               ((dx != cx1) || (dy != cy1));
    rule[6]  = (cx != cmax) && !hw && eok && ((dx > cx1) || ((dx > cx) && (dy == cy1)));
    rule[7]  = (cy != cmax) && !hs && nok && (dy > cy);
    rule[8]  = (cx != '0) && (cx >= dx) && (!he || ((cy1 == dy) && (cx == dx))) && wok;
    rule[9]  = (cy != '0) && (cy >= dy) && !hn && sok &&
               (!he || (dx != cmax) || (dy != cmax));
    rule[10] = (cx != cmax) && (cx <= dx) &&
               (!hw || (cx == dx) || ((cx1 == dx) && (cy1 != dy))) && eok;
    rule[11] = (cy != cmax) && (cy <= dy) && (!hs || (cx <= dx)) && nok;
  end

  always_comb begin
    res_o.arrived = (cx == dx) && (cy == dy);
    res_o.stuck   = 1'b0;
    if      (rule[0])  res_o.mv = DIR_W;
    else if (rule[1])  res_o.mv = DIR_S;
    else if (rule[2])  res_o.mv = DIR_E;
    else if (rule[3])  res_o.mv = DIR_N;
    else if (rule[4])  res_o.mv = DIR_W;
    else if (rule[5])  res_o.mv = DIR_S;
    else if (rule[6])  res_o.mv = DIR_E;
    else if (rule[7])  res_o.mv = DIR_N;
    else if (rule[8])  res_o.mv = DIR_W;
    else if (rule[9])  res_o.mv = DIR_S;
    else if (rule[10]) res_o.mv = DIR_E;
    else if (rule[11]) res_o.mv = DIR_N;
    else begin
      res_o.mv    = DIR_NEW;
      res_o.stuck = !res_o.arrived;
    end
  end

endmodule

// File: design/fault_tolerant_mesh_route_walk_core.sv
`timescale 1ns / 1ps

// Fault-tolerant route walk over a 3x3 mesh.
// Input channel (in_valid_i / in_stall_o): one transaction carries a start node
// and a destination node; coordinates of 3 are treated as 2. Output channel
// (out_valid_o / out_stall_i): one transaction per input carries the outcome
// (delivered, unroutable, livelock), the number of moves and the final node.
// Config: cfg_we_i writes link_ok (index 0) or hop_limit (index 1) from
// cfg_data_i; write only while no walk is in flight.
// Timing: the shared hop unit decides one move per cycle. A delivered or
// unroutable walk ends with a separate final decision after its last move;
// for livelock the last move is also the final decision.
// in_stall_o is high for the whole walk. The output register frees the walker
// from the receiver: the next walk can start while a result is still stalled,
// and a walk that is ready to finish just waits on its final decision until
// the output register empties. Back-pressure never loses or repeats a result.
// Reset: asynchronous, active low; clears the walker and output valid and
// restores link_ok to all ones and hop_limit to 1000. No clearing pass.

module fault_tolerant_mesh_route_walk_core import ftmrw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LinkW-1:0]    cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CoordW-1:0]   start_x_i,
  input  logic [CoordW-1:0]   start_y_i,
  input  logic [CoordW-1:0]   dest_x_i,
  input  logic [CoordW-1:0]   dest_y_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          outcome_o,
  output logic [CountW-1:0]   hop_count_o,
  output logic [CoordW-1:0]   final_x_o,
  output logic [CoordW-1:0]   final_y_o
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e             state_q;
  logic [LinkW-1:0]   link_ok_q;
  logic [LimitW-1:0]  hop_limit_q;

  // walker state
  logic [CoordW-1:0]  pos_x_q, pos_y_q, dst_x_q, dst_y_q;
  dir_e               heading_q;
  logic [CountW-1:0]  cnt_q;

  // output register
  logic               out_valid_q;
  outcome_e           outcome_q;
  logic [CountW-1:0]  hop_count_q;
  logic [CoordW-1:0]  final_x_q, final_y_q;

  logic [CoordW-1:0]  sx_sat, sy_sat, dx_sat, dy_sat;
  logic [NodeW-1:0]   node_idx;
  logic [3:0]         links;
  hop_res_t           hop;
  logic [CoordW-1:0]  nxt_x, nxt_y;
  logic [CountW-1:0]  cnt_inc;
  logic               over_limit, finish, out_busy, in_acc;

  assign sx_sat = (start_x_i > CoordMax) ? CoordMax : start_x_i;
  assign sy_sat = (start_y_i > CoordMax) ? CoordMax : start_y_i;
  assign dx_sat = (dest_x_i  > CoordMax) ? CoordMax : dest_x_i;
  assign dy_sat = (dest_y_i  > CoordMax) ? CoordMax : dest_y_i;

  // link nibble of the current node: node = x*3 + y, nibble at node*4
  assign node_idx = NodeW'({pos_x_q, 1'b0}) + NodeW'(pos_x_q) + NodeW'(pos_y_q);
  assign links    = link_ok_q[{node_idx, 2'b00} +: 4];

  ftmrw_hop u_hop (
    .cur_x_i   (pos_x_q),
    .cur_y_i   (pos_y_q),
    .dst_x_i   (dst_x_q),
    .dst_y_i   (dst_y_q),
    .heading_i (heading_q),
    .links_i   (links),
    .res_o     (hop)
  );

  always_comb begin
    nxt_x = pos_x_q;
    nxt_y = pos_y_q;
    unique case (hop.mv)
      DIR_W:   nxt_x = pos_x_q - 2'd1;
      DIR_S:   nxt_y = pos_y_q - 2'd1;
      DIR_E:   nxt_x = pos_x_q + 2'd1;
      DIR_N:   nxt_y = pos_y_q + 2'd1;
      default: ;
    endcase
  end

  assign cnt_inc    = cnt_q + 12'd1;
  // the move that finds the count already at the limit declares livelock
  assign over_limit = (cnt_q >= {1'b0, hop_limit_q});
  assign finish     = hop.arrived || hop.stuck || over_limit;
  assign out_busy   = out_valid_q && out_stall_i;

  assign in_stall_o = (state_q == ST_WALK);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      link_ok_q   <= LinkOkReset;
      hop_limit_q <= HopLimitReset;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= DIR_NEW;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LINK_OK:   link_ok_q   <= cfg_data_i;
          CFG_HOP_LIMIT: hop_limit_q <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pos_x_q   <= sx_sat;
            pos_y_q   <= sy_sat;
            dst_x_q   <= dx_sat;
            dst_y_q   <= dy_sat;
            heading_q <= DIR_NEW;
            cnt_q     <= '0;
            state_q   <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!finish) begin
            pos_x_q   <= nxt_x;
            pos_y_q   <= nxt_y;
            heading_q <= hop.mv;
            cnt_q     <= cnt_inc;
          end else if (!out_busy) begin
            // final decision; held back while the output register is full and stalled
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (hop.arrived) begin
              outcome_q   <= OUT_DELIVERED;
              hop_count_q <= cnt_q;
              final_x_q   <= pos_x_q;
              final_y_q   <= pos_y_q;
            end else if (hop.stuck) begin
              outcome_q   <= OUT_UNROUTABLE;
              hop_count_q <= cnt_q;
              final_x_q   <= pos_x_q;
              final_y_q   <= pos_y_q;
            end else begin
              outcome_q   <= OUT_LIVELOCK;
              hop_count_q <= cnt_inc;
              final_x_q   <= nxt_x;
              final_y_q   <= nxt_y;
              pos_x_q     <= nxt_x;
              pos_y_q     <= nxt_y;
              heading_q   <= hop.mv;
              cnt_q       <= cnt_inc;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;
  assign hop_count_o = hop_count_q;
  assign final_x_o   = final_x_q;
  assign final_y_o   = final_y_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ftmrw_pkg::*;

  localparam int unsigned MaxGap      = 18;
  // longest correct walk is hop_limit 2047 -> 2048 moves, plus a full
  // receiver stall and sender gap; leave a wide margin
  localparam int unsigned QuietLimit  = 12000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomItems = 570;
  // links that leave the mesh: west of column 0, east of column 2,
  // south of row 0, north of row 2
  localparam logic [LinkW-1:0] OffMeshLinks = 36'hC4680_2913;

  typedef struct packed {
    outcome_e          outcome;
    logic [CountW-1:0] hops;
    logic [CoordW-1:0] fx;
    logic [CoordW-1:0] fy;
  } walk_result_t;

  // Tracks the link mask and hop limit, predicts each walk when its
  // transaction is accepted and checks results in order.
  class walk_scoreboard;
    logic [LinkW-1:0]  link_ok;
    logic [LimitW-1:0] hop_limit;
    walk_result_t      pending_walks[$];
    int unsigned       errors;

    function new();
      link_ok   = LinkOkReset;
      hop_limit = HopLimitReset;
      errors    = 0;
    endfunction

    function void set_config(logic [LinkW-1:0] link, logic [LimitW-1:0] limit);
      link_ok   = link;
      hop_limit = limit;
    endfunction

    function bit link_up(int x, int y, dir_e d);
      return link_ok[(x * 3 + y) * 4 + int'(d)];
    endfunction

    function int sat_coord(logic [CoordW-1:0] v);
      return (v > CoordMax) ? int'(CoordMax) : int'(v);
    endfunction

    // one full walk, one decision per loop pass
    function walk_result_t walk_route(logic [CoordW-1:0] sx, logic [CoordW-1:0] sy,
                                      logic [CoordW-1:0] tx, logic [CoordW-1:0] ty);
      int cx, cy, dx, dy, counted, moves;
      bit wok, sok, eok, nok, fromws, done;
      dir_e h, mv;
      walk_result_t r;
      cx = sat_coord(sx);
      cy = sat_coord(sy);
      dx = sat_coord(tx);
      dy = sat_coord(ty);
      h = DIR_NEW;
      counted = 0;
      moves = 0;
      done = 0;
      r.outcome = OUT_DELIVERED;
      while (!done) begin
        if (cx == dx && cy == dy) begin
          r.outcome = OUT_DELIVERED;
          done = 1;
        end else begin
          wok = link_up(cx, cy, DIR_W);
          sok = link_up(cx, cy, DIR_S);
          eok = link_up(cx, cy, DIR_E);
          nok = link_up(cx, cy, DIR_N);
          fromws = (h == DIR_W || h == DIR_S || h == DIR_NEW);
          mv = DIR_NEW;
          // turn rules in priority order; DIR_NEW left means nothing applies
          if (cx == dx + 1 && cy == dy && wok) mv = DIR_W;
          else if (cy == dy + 1 && cx == dx && sok) mv = DIR_S;
          else if (cx + 1 == dx && cy == dy && eok) mv = DIR_E;
          else if (cy + 1 == dy && cx == dx && nok) mv = DIR_N;
          else if (cx != 0 && fromws && wok && (cx >= dx || (cy <= dy && !sok)))
            mv = DIR_W;
          else if (cy != 0 && fromws && sok && (cy >= dy || (cx <= dx && !wok)) &&
                   (dx != cx + 1 || dy != cy + 1))
            mv = DIR_S;
          else if (cx != 2 && h != DIR_W && eok &&
                   (dx > cx + 1 || (dx > cx && dy == cy + 1)))
            mv = DIR_E;
          else if (cy != 2 && h != DIR_S && nok && dy > cy) mv = DIR_N;
          else if (cx != 0 && cx >= dx && (h != DIR_E || (cy + 1 == dy && cx == dx)) &&
                   wok)
            mv = DIR_W;
          else if (cy != 0 && cy >= dy && h != DIR_N && sok &&
                   (h != DIR_E || dx != 2 || dy != 2))
            mv = DIR_S;
          else if (cx != 2 && cx <= dx &&
                   (h != DIR_W || cx == dx || (cx + 1 == dx && cy + 1 != dy)) && eok)
            mv = DIR_E;
          else if (cy != 2 && cy <= dy && (h != DIR_S || cx <= dx) && nok) mv = DIR_N;

          if (mv == DIR_NEW) begin
            r.outcome = OUT_UNROUTABLE;
            done = 1;
          end else begin
            case (mv)
              DIR_W:   cx--;
              DIR_S:   cy--;
              DIR_E:   cx++;
              default: cy++;
            endcase
            h = mv;
            moves++;
            // the move past the limit still counts, even onto the destination
            if (counted >= int'(hop_limit)) begin
              r.outcome = OUT_LIVELOCK;
              done = 1;
            end else begin
              counted++;
            end
          end
        end
      end
      r.hops = moves[CountW-1:0];
      r.fx   = cx[CoordW-1:0];
      r.fy   = cy[CoordW-1:0];
      return r;
    endfunction

    function void note_walk(logic [CoordW-1:0] sx, logic [CoordW-1:0] sy,
                            logic [CoordW-1:0] tx, logic [CoordW-1:0] ty);
      pending_walks.push_back(walk_route(sx, sy, tx, ty));
    endfunction

    function void check_result(logic [1:0] outcome, logic [CountW-1:0] hops,
                               logic [CoordW-1:0] fx, logic [CoordW-1:0] fy);
      walk_result_t w;
      if (pending_walks.size() == 0) begin
        $display("%0t: unexpected result: outcome %0d hops %0d at (%0d,%0d)",
                 $time, outcome, hops, fx, fy);
        errors++;
        return;
      end
      w = pending_walks.pop_front();
      if (outcome !== w.outcome) begin
        $display("%0t: outcome mismatch: expected %0d, got %0d", $time, w.outcome, outcome);
        errors++;
      end
      if (hops !== w.hops) begin
        $display("%0t: hop_count mismatch: expected %0d, got %0d", $time, w.hops, hops);
        errors++;
      end
      if (fx !== w.fx) begin
        $display("%0t: final_x mismatch: expected %0d, got %0d", $time, w.fx, fx);
        errors++;
      end
      if (fy !== w.fy) begin
        $display("%0t: final_y mismatch: expected %0d, got %0d", $time, w.fy, fy);
        errors++;
      end
    endfunction

    function int pending();
      return pending_walks.size();
    endfunction

    function void close();
      if (pending_walks.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, pending_walks.size());
        errors += pending_walks.size();
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [LinkW-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CoordW-1:0]   start_x_i;
  logic [CoordW-1:0]   start_y_i;
  logic [CoordW-1:0]   dest_x_i;
  logic [CoordW-1:0]   dest_y_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          outcome_o;
  logic [CountW-1:0]   hop_count_o;
  logic [CoordW-1:0]   final_x_o;
  logic [CoordW-1:0]   final_y_o;

  walk_scoreboard sb;
  bit             tx_idle;     // sender inserts random gaps
  bit             rx_idle;     // receiver inserts random stalls
  int unsigned    quiet_cycles;

  fault_tolerant_mesh_route_walk_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .dest_x_i    (dest_x_i),
    .dest_y_i    (dest_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .outcome_o   (outcome_o),
    .hop_count_o (hop_count_o),
    .final_x_o   (final_x_o),
    .final_y_o   (final_y_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Push one route request. The walk is predicted at the edge where the
  // transaction is accepted, so prediction always precedes its result.
  // Valid is only lowered when a gap follows, never dropped and re-raised
  // in the same step.
  task automatic send_walk(logic [CoordW-1:0] sx, logic [CoordW-1:0] sy,
                           logic [CoordW-1:0] tx, logic [CoordW-1:0] ty);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    dest_x_i   <= tx;
    dest_y_i   <= ty;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_walk(sx, sy, tx, ty);
  endtask

  // Stop sending and wait until every walk in flight has reported back.
  // Each request yields exactly one result, so the walker is idle then.
  task automatic drain_walks();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Both registers, back to back; only called while idle.
  task automatic write_config(logic [LinkW-1:0] link, logic [LimitW-1:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LINK_OK;
    cfg_data_i <= link;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HOP_LIMIT;
    cfg_data_i <= {{(LinkW - LimitW){1'b0}}, limit};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_config(link, limit);
  endtask

  // Result side: random stall ahead of each result, then take it.
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = rx_idle ? $urandom_range(0, MaxGap) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Output monitor: values seen here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(outcome_o, hop_count_o, final_x_o, final_y_o);
    end
  end

  // Watchdog: any accepted transaction or register write counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0]       r;
    logic [LinkW-1:0]  link;
    logic [LimitW-1:0] limit;
    int unsigned       kind, faults, items, random_sent;

    sb           = new();
    quiet_cycles = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_LINK_OK;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    start_x_i    = '0;
    start_y_i    = '0;
    dest_x_i     = '0;
    dest_y_i     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed, reset configuration: full mesh, limit 1000
    send_walk(2'd0, 2'd0, 2'd0, 2'd0);   // already there
    send_walk(2'd0, 2'd0, 2'd2, 2'd2);   // corner to corner, both ways
    send_walk(2'd2, 2'd2, 2'd0, 2'd0);
    send_walk(2'd2, 2'd0, 2'd0, 2'd2);
    send_walk(2'd0, 2'd2, 2'd2, 2'd0);
    send_walk(2'd3, 2'd3, 2'd0, 2'd0);   // coordinate 3 acts as 2
    send_walk(2'd0, 2'd0, 2'd3, 2'd3);
    send_walk(2'd3, 2'd1, 2'd1, 2'd3);
    send_walk(2'd1, 2'd1, 2'd0, 2'd1);   // one hop in each direction
    send_walk(2'd1, 2'd1, 2'd1, 2'd0);
    send_walk(2'd1, 2'd1, 2'd2, 2'd1);
    send_walk(2'd1, 2'd1, 2'd1, 2'd2);
    drain_walks();

    // no usable link at all: everything but a null walk is unroutable
    write_config('0, 11'd2047);
    send_walk(2'd0, 2'd0, 2'd2, 2'd2);
    send_walk(2'd1, 2'd1, 2'd1, 2'd1);
    send_walk(2'd3, 2'd0, 2'd0, 2'd3);
    drain_walks();

    // zero hop limit: a walk that has to move livelocks on its very first move
    write_config(LinkOkReset, 11'd0);
    send_walk(2'd0, 2'd0, 2'd2, 2'd2);
    send_walk(2'd2, 2'd2, 2'd2, 2'd2);
    drain_walks();

    // limit 1: the second move trips livelock even when it lands on target
    write_config(LinkOkReset, 11'd1);
    send_walk(2'd0, 2'd0, 2'd0, 2'd2);
    send_walk(2'd0, 2'd0, 2'd1, 2'd0);
    drain_walks();

    // links off the mesh cleared: moves off the edge never happen anyway
    write_config(~OffMeshLinks, HopLimitReset);
    send_walk(2'd0, 2'd0, 2'd2, 2'd2);
    send_walk(2'd2, 2'd2, 2'd0, 2'd0);
    send_walk(2'd0, 2'd2, 2'd2, 2'd0);
    send_walk(2'd2, 2'd0, 2'd0, 2'd2);
    send_walk(2'd1, 2'd1, 2'd0, 2'd0);
    drain_walks();

    // --- random phases; each one drains fully before the next write,
    // which also gives the sender a pause until every result is back
    random_sent = 0;
    while (random_sent < RandomItems) begin
      kind = $urandom_range(0, 5);
      r = {$urandom(), $urandom()};
      case (kind)
        0: link = LinkOkReset;
        4: link = r[LinkW-1:0];
        5: link = r[LinkW-1:0] & r[63:64-LinkW];  // sparse mesh
        default: begin
          // a handful of faults, where routing gets interesting
          link = LinkOkReset;
          faults = $urandom_range(1, 5);
          repeat (faults) link[$urandom_range(0, LinkW - 1)] = 1'b0;
        end
      endcase
      case ($urandom_range(0, 7))
        0: limit = 11'd2047;
        1: limit = HopLimitReset;
        2: limit = 11'd0;
        3: limit = 11'($urandom_range(0, 2047));
        default: limit = 11'($urandom_range(1, 40));
      endcase
      // long limits make livelocked walks slow, so keep those phases short
      items = (limit > 11'd64) ? 15 : 60;
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      write_config(link, limit);
      repeat (items) begin
        send_walk(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
      random_sent += items;
      drain_walks();
    end

    repeat (DrainCycles) @(posedge clk_i);
    sb.close();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
